@@ design/fbrc_pkg.sv @@
// Shared types, constants and helper functions of the forbidden address range checker.
// Depends on nothing; the core, datapath and controller import it.
package fbrc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 64;

	localparam int IN_DATA_W  = 208;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 8;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	localparam logic [1:0] SRC_MEMMAP   = 2'd0;
	localparam logic [1:0] SRC_RESERVED = 2'd1;
	localparam logic [1:0] SRC_ATTR     = 2'd2;
	localparam logic [1:0] NO_SOURCE    = 2'd3;

	localparam logic [3:0] MT_LOADER_CODE   = 4'd1;
	localparam logic [3:0] MT_LOADER_DATA   = 4'd2;
	localparam logic [3:0] MT_BS_CODE       = 4'd3;
	localparam logic [3:0] MT_BS_DATA       = 4'd4;
	localparam logic [3:0] MT_RT_CODE       = 4'd5;
	localparam logic [3:0] MT_RT_DATA       = 4'd6;
	localparam logic [3:0] MT_CONVENTIONAL  = 4'd7;
	localparam logic [3:0] MT_UNUSABLE      = 4'd8;
	localparam logic [3:0] MT_ACPI_RECLAIM  = 4'd9;

	// One table slot as stored: the class decision and the exclusive end are
	// worked out when the slot is loaded, so a scan only compares.
	typedef struct packed {
		logic              forbids;
		logic [1:0]        source;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W:0]   limit;
	} slot_t;

	typedef struct packed {
		logic capture;
		logic clear_tbl;
		logic write_slot;
		logic scan_issue;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic issue_last;
		logic out_free;
	} sts_t;

	function automatic logic forbid_class(input logic [1:0] src, input logic [3:0] mtype,
			input logic ro);
		logic res;
		res = 1'b0;
		case (src)
			SRC_MEMMAP: begin
				case (mtype)
					MT_LOADER_CODE, MT_LOADER_DATA, MT_BS_CODE, MT_BS_DATA,
					MT_CONVENTIONAL, MT_UNUSABLE, MT_ACPI_RECLAIM: res = 1'b1;
					default: res = 1'b0;
				endcase
			end
			SRC_RESERVED: res = 1'b1;
			SRC_ATTR: res = ro && (mtype == MT_RT_CODE || mtype == MT_RT_DATA);
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	// Exclusive end of a region, one bit wider than an address so it never wraps.
	function automatic logic [ADDR_W:0] region_limit(input logic [1:0] src,
			input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] size);
		logic [ADDR_W:0] res;
		res = '0;
		if (src == SRC_RESERVED) begin
			res = {1'b0, start} + {1'b0, size};
		end else if (size[ADDR_W-1 -: PAGE_SHIFT] != '0) begin
			res = {1'b1, {ADDR_W{1'b0}}};
		end else begin
			res = {1'b0, start} + {1'b0, size[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
		end
		return res;
	endfunction

endpackage

@@ design/forbidden_address_range_checker_core.sv @@
// Address firewall with a loadable region table of TABLE_DEPTH slots.
// Input words arrive on s_axis; tuser carries the opcode and region source,
// tdata the slot index, region attributes, base, size and checked address.
// Opcode load writes one slot, clear empties the table, an enabled check scans it.
// Every word gives exactly one result word on m_axis: forbidden flag and
// the lowest matching source (3 when none or not a check).
// The single restriction-enable register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce. A new word is accepted in the cycle after
// the previous result is published. The check time is set by the table RAM,
// read one slot per cycle through its single read port. One word is processed
// at a time; the next is accepted once the result has moved into the output
// register, even if the receiver has not taken it yet. A stalled receiver holds
// the result and, after one more word has finished, stops acceptance.
// Reset empties the table, clears the enable and the output valid.
module forbidden_address_range_checker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// entry_index, region_type, region_read_only, region_start, region_size,
	// check_address
	input  logic [fbrc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode, region_source
	input  logic [fbrc_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// forbidden, hit_source
	output logic [fbrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data
);
	import fbrc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic restrict_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restrict_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			restrict_en_q <= cfg_wr_data;
		end
	end

	fbrc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (s_axis_tuser[1:0]),
		.enable  (restrict_en_q),
		.in_ready(s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	fbrc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

	// Commands of different phases never overlap.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_slot, cmd.scan_issue, cmd.publish, cmd.capture}))
		else $error("controller issued overlapping commands");

	// A result is only published into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result published over an untaken word");

	// A forbidden result always names the source that matched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] != NO_SOURCE))
		else $error("forbidden result without a hit source");

	// An enabled check starts scanning in the cycle after it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == OP_CHECK && restrict_en_q)
		|=> cmd.scan_issue)
		else $error("check word did not start a table scan");
endmodule

@@ design/fbrc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the region table of the checker.
module fbrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/fbrc_datapath.sv @@
// Datapath of the range checker: captured word, valid bits, region table RAM,
// scan counter, match/accumulate stage and output register. Uses fbrc_pkg, fbrc_ram.
module fbrc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fbrc_pkg::cmd_t                      cmd,
	output fbrc_pkg::sts_t                      sts,
	input  logic [fbrc_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [fbrc_pkg::IN_USER_W-1:0]      in_user,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fbrc_pkg::OUT_DATA_W-1:0]     out_data
);
	import fbrc_pkg::*;

	logic [5:0]        idx_q;
	logic [1:0]        src_q;
	logic [3:0]        type_q;
	logic              ro_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [SLOT_W-1:0]      cnt_q;
	logic                   issue_s1;
	logic                   vld_s1;
	logic                   forbidden_q;
	logic [1:0]             hit_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	logic [31:0]       idx_ext;
	logic              in_range;
	logic [SLOT_W-1:0] waddr;
	slot_t             wslot;
	slot_t             rslot;
	logic              match;

	assign idx_ext  = 32'(idx_q);
	assign in_range = idx_ext < 32'(TABLE_DEPTH);
	assign waddr    = idx_ext[SLOT_W-1:0];

	always_comb begin
		wslot.forbids = forbid_class(src_q, type_q, ro_q);
		wslot.source  = src_q;
		wslot.start   = start_q;
		wslot.limit   = region_limit(src_q, start_q, size_q);
	end

	fbrc_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.write_slot && in_range),
		.waddr(waddr),
		.wdata(wslot),
		.raddr(cnt_q),
		.rdata(rslot)
	);

	assign match = issue_s1 && vld_s1 && rslot.forbids && (addr_q >= rslot.start)
		&& ({1'b0, addr_q} < rslot.limit);

	assign sts.issue_last = (cnt_q == SLOT_W'(TABLE_DEPTH - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Captured word and accumulators carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q       <= in_data[5:0];
			type_q      <= in_data[9:6];
			ro_q        <= in_data[10];
			start_q     <= in_data[74:11];
			size_q      <= in_data[138:75];
			addr_q      <= in_data[202:139];
			src_q       <= in_user[3:2];
			forbidden_q <= 1'b0;
			hit_q       <= NO_SOURCE;
		end else if (match) begin
			forbidden_q <= 1'b1;
			if (rslot.source < hit_q) begin
				hit_q <= rslot.source;
			end
		end
		vld_s1 <= valid_q[cnt_q];
		if (cmd.publish) begin
			out_data_q <= {{(OUT_DATA_W-3){1'b0}}, hit_q, forbidden_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_tbl) begin
				valid_q <= '0;
			end else if (cmd.write_slot && in_range) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.scan_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			issue_s1 <= cmd.scan_issue;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

@@ design/fbrc_ctrl.sv @@
// Controller of the range checker: sequences load, clear and check words and
// drives the datapath commands. Uses fbrc_pkg.
module fbrc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_op,
	input  logic           enable,
	output logic           in_ready,
	output fbrc_pkg::cmd_t cmd,
	input  fbrc_pkg::sts_t sts
);
	import fbrc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.capture    = accept;
		cmd.clear_tbl  = accept && (in_op == OP_CLEAR);
		cmd.write_slot = (state_q == ST_WRITE);
		cmd.scan_issue = (state_q == ST_SCAN);
		cmd.publish    = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_LOAD) begin
							state_q <= ST_WRITE;
						end else if (in_op == OP_CHECK && enable) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WRITE: state_q <= ST_DONE;
				ST_SCAN: begin
					if (sts.issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				// The last slot read is still being compared in this cycle.
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
